@@ rtl/planar_three_link_forward_kinematics_unit_assert.svh @@
// Assertion macros used by the port-level checker.
`ifndef PLANAR_THREE_LINK_FORWARD_KINEMATICS_UNIT_ASSERT_SVH
`define PLANAR_THREE_LINK_FORWARD_KINEMATICS_UNIT_ASSERT_SVH

// Clocked implication checked outside reset.
`define P3FK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked property also checked during reset.
`define P3FK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/p3fk_pkg.sv @@
// Package with shared constants, types and the arctangent table of the unit.
`timescale 1ns / 1ps

package p3fk_pkg;

    localparam int ANGLE_BITS  = 16;
    localparam int TRIG_STAGES = 16;
    localparam int TABLE_LEN   = 24;
    localparam int LEN_W       = 16;
    localparam int TRIG_W      = 16;
    localparam int POS_W       = 19;
    localparam int CORD_W      = 34;
    localparam int PROD_W      = 33;
    localparam int SUM_W       = 36;
    localparam int CFG_IDX_W   = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_LINK_ONE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_TWO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_THREE = 2'd2;

    localparam logic [LEN_W-1:0] LEN_RESET = 16'd256;
    localparam logic signed [CORD_W-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] TRIG_MAX = 16'sd32767;

    // Lane latency: fold stage, rotation stages, rounding stage.
    localparam int LANE_LAT  = TRIG_STAGES + 2;
    localparam int MERGE_LAT = 2;
    localparam int TOTAL_LAT = LANE_LAT + MERGE_LAT;

    localparam int IN_W  = 3 * ANGLE_BITS;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W = 2 * POS_W + ANGLE_BITS + 2 * TRIG_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef logic [ANGLE_BITS-1:0] angle_t;
    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef struct packed {
        logic [LEN_W-1:0] one;
        logic [LEN_W-1:0] two;
        logic [LEN_W-1:0] three;
    } links_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [CORD_W-1:0] atan_turn(input int idx);
        logic signed [CORD_W-1:0] r;
        case (idx)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933405;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335086;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41721;
            15: r = 34'sd20860;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2607;
            19: r = 34'sd1303;
            20: r = 34'sd651;
            21: r = 34'sd325;
            22: r = 34'sd162;
            23: r = 34'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/p3fk_cordic_lane.sv @@
// One pipelined rotation-mode CORDIC lane giving saturated Q1.15 cos and sin.
`timescale 1ns / 1ps

module p3fk_cordic_lane (
    input  logic            clk,
    input  logic            advance,
    input  p3fk_pkg::angle_t angle,
    output p3fk_pkg::trig_t cos_val,
    output p3fk_pkg::trig_t sin_val
);

    localparam int W = p3fk_pkg::CORD_W;
    localparam int N = p3fk_pkg::TRIG_STAGES;

    logic signed [W-1:0] x_reg [0:N];
    logic signed [W-1:0] y_reg [0:N];
    logic signed [W-1:0] z_reg [0:N];
    logic                flip_reg [0:N];
    logic signed [W-1:0] z_wide;
    logic signed [W-1:0] z_fold;
    logic                flip_fold;
    logic signed [W-1:0] x_fin;
    logic signed [W-1:0] y_fin;
    logic signed [W-1:0] x_rnd;
    logic signed [W-1:0] y_rnd;
    p3fk_pkg::trig_t     cos_reg;
    p3fk_pkg::trig_t     sin_reg;

    // Widen the angle to 2^32 per turn and fold it into a quarter turn around zero.
    always_comb
    begin
        z_wide = W'(signed'({angle, {(32 - p3fk_pkg::ANGLE_BITS){1'b0}}}));
        z_fold = z_wide;
        flip_fold = 1'b0;
        if (z_wide > (W'(1) <<< 30))
        begin
            z_fold = z_wide - (W'(1) <<< 31);
            flip_fold = 1'b1;
        end
        else if (z_wide < -(W'(1) <<< 30))
        begin
            z_fold = z_wide + (W'(1) <<< 31);
            flip_fold = 1'b1;
        end
    end

    // Rotation stages, one per cycle while advance is high.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0]    <= p3fk_pkg::CORDIC_START;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_fold;
            flip_reg[0] <= flip_fold;
            for (int i = 0; i < N; i++)
            begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - p3fk_pkg::atan_turn(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + p3fk_pkg::atan_turn(i);
                end
            end
        end
    end

    // Undo the fold, round Q2.30 to Q1.15 and saturate.
    always_comb
    begin
        x_fin = flip_reg[N] ? -x_reg[N] : x_reg[N];
        y_fin = flip_reg[N] ? -y_reg[N] : y_reg[N];
        x_rnd = (x_fin + W'(16384)) >>> 15;
        y_rnd = (y_fin + W'(16384)) >>> 15;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (x_rnd > W'(p3fk_pkg::TRIG_MAX))
                cos_reg <= p3fk_pkg::TRIG_MAX;
            else if (x_rnd < -W'(p3fk_pkg::TRIG_MAX))
                cos_reg <= -p3fk_pkg::TRIG_MAX;
            else
                cos_reg <= x_rnd[p3fk_pkg::TRIG_W-1:0];
            if (y_rnd > W'(p3fk_pkg::TRIG_MAX))
                sin_reg <= p3fk_pkg::TRIG_MAX;
            else if (y_rnd < -W'(p3fk_pkg::TRIG_MAX))
                sin_reg <= -p3fk_pkg::TRIG_MAX;
            else
                sin_reg <= y_rnd[p3fk_pkg::TRIG_W-1:0];
        end
    end

    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

@@ rtl/p3fk_merge.sv @@
// Merging stage: scales each lane's trig values by its link length and sums.
`timescale 1ns / 1ps

module p3fk_merge (
    input  logic            clk,
    input  logic            advance,
    input  p3fk_pkg::links_t links,
    input  p3fk_pkg::trig_t cos_one,
    input  p3fk_pkg::trig_t sin_one,
    input  p3fk_pkg::trig_t cos_two,
    input  p3fk_pkg::trig_t sin_two,
    input  p3fk_pkg::trig_t cos_three,
    input  p3fk_pkg::trig_t sin_three,
    output logic signed [p3fk_pkg::POS_W-1:0] tip_x,
    output logic signed [p3fk_pkg::POS_W-1:0] tip_y
);

    localparam int PW = p3fk_pkg::PROD_W;
    localparam int SW = p3fk_pkg::SUM_W;

    logic signed [PW-1:0] px_reg [0:2];
    logic signed [PW-1:0] py_reg [0:2];
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    logic signed [SW-1:0] rnd_x;
    logic signed [SW-1:0] rnd_y;
    logic signed [p3fk_pkg::POS_W-1:0] x_reg;
    logic signed [p3fk_pkg::POS_W-1:0] y_reg;

    // Products of length and trig value, one multiplier each.
    // Both operands are widened to the full product width before multiplying.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_reg[0] <= PW'(signed'({1'b0, links.one})) * PW'(cos_one);
            py_reg[0] <= PW'(signed'({1'b0, links.one})) * PW'(sin_one);
            px_reg[1] <= PW'(signed'({1'b0, links.two})) * PW'(cos_two);
            py_reg[1] <= PW'(signed'({1'b0, links.two})) * PW'(sin_two);
            px_reg[2] <= PW'(signed'({1'b0, links.three})) * PW'(cos_three);
            py_reg[2] <= PW'(signed'({1'b0, links.three})) * PW'(sin_three);
        end
    end

    // Sum and round back to Q11.8.
    always_comb
    begin
        sum_x = SW'(px_reg[0]) + SW'(px_reg[1]) + SW'(px_reg[2]);
        sum_y = SW'(py_reg[0]) + SW'(py_reg[1]) + SW'(py_reg[2]);
        rnd_x = (sum_x + SW'(16384)) >>> 15;
        rnd_y = (sum_y + SW'(16384)) >>> 15;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg <= rnd_x[p3fk_pkg::POS_W-1:0];
            y_reg <= rnd_y[p3fk_pkg::POS_W-1:0];
        end
    end

    assign tip_x = x_reg;
    assign tip_y = y_reg;

endmodule

@@ rtl/planar_three_link_forward_kinematics_unit.sv @@
// Top level of the planar three-link forward kinematics unit.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  three joint angles
//  m_*      out        m_tvalid/m_tready  tip position, heading, cos, sin
//  cfg_*    in         cfg_valid/cfg_ready link lengths by index
//
// One item per cycle is accepted while the output is not stalled; each result passes
// through the CORDIC fold, rotation and rounding stages and then the product and sum stages.
// The whole pipeline holds when a result waits at the output; cfg_ready is always high.
// Reset clears the valid pipeline and sets every link length to 1.0.
`timescale 1ns / 1ps

module planar_three_link_forward_kinematics_unit (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // joint_one_angle [15:0], joint_two_angle [31:16], joint_three_angle [47:32]
    input  logic [p3fk_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // tip_x [18:0], tip_y [37:19], heading_angle [53:38], heading_cos [69:54],
    // heading_sin [85:70], zero fill [87:86]
    output logic [p3fk_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [p3fk_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [p3fk_pkg::LEN_W-1:0] cfg_data
);

    localparam int AB = p3fk_pkg::ANGLE_BITS;
    localparam int L  = p3fk_pkg::TOTAL_LAT;

    p3fk_pkg::links_t links_reg;
    logic [L-1:0]     valid_reg;
    p3fk_pkg::angle_t head_reg [0:L-1];
    logic             advance;
    p3fk_pkg::angle_t a1;
    p3fk_pkg::angle_t a12;
    p3fk_pkg::angle_t a123;
    p3fk_pkg::trig_t  c1, s1, c2, s2, c3, s3;
    logic signed [p3fk_pkg::POS_W-1:0] tip_x;
    logic signed [p3fk_pkg::POS_W-1:0] tip_y;

    // The pipeline moves whenever the output register is free or being taken.
    assign advance   = !m_tvalid || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    // Cumulative joint angles, wrapping modulo one turn.
    assign a1   = s_tdata[AB-1:0];
    assign a12  = a1 + s_tdata[2*AB-1:AB];
    assign a123 = a12 + s_tdata[3*AB-1:2*AB];

    // Link length registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            links_reg.one   <= p3fk_pkg::LEN_RESET;
            links_reg.two   <= p3fk_pkg::LEN_RESET;
            links_reg.three <= p3fk_pkg::LEN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                p3fk_pkg::REG_LINK_ONE:   links_reg.one   <= cfg_data;
                p3fk_pkg::REG_LINK_TWO:   links_reg.two   <= cfg_data;
                p3fk_pkg::REG_LINK_THREE: links_reg.three <= cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits track items through the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[L-2:0], s_tvalid};
    end

    // Heading travels alongside the lanes.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            head_reg[0] <= a123;
            for (int i = 1; i < L; i++)
                head_reg[i] <= head_reg[i-1];
        end
    end

    // Three trig lanes, one per cumulative angle.
    p3fk_cordic_lane u_lane_one (
        .clk(clk), .advance(advance), .angle(a1), .cos_val(c1), .sin_val(s1)
    );
    p3fk_cordic_lane u_lane_two (
        .clk(clk), .advance(advance), .angle(a12), .cos_val(c2), .sin_val(s2)
    );
    p3fk_cordic_lane u_lane_three (
        .clk(clk), .advance(advance), .angle(a123), .cos_val(c3), .sin_val(s3)
    );

    // Merge the lanes into the tip position.
    p3fk_merge u_merge (
        .clk(clk), .advance(advance), .links(links_reg),
        .cos_one(c1), .sin_one(s1), .cos_two(c2), .sin_two(s2),
        .cos_three(c3), .sin_three(s3), .tip_x(tip_x), .tip_y(tip_y)
    );

    // Heading trig is delayed through c3_d_reg and s3_d_reg to line up with the merged position.
    p3fk_pkg::trig_t c3_d_reg [0:1];
    p3fk_pkg::trig_t s3_d_reg [0:1];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c3_d_reg[0] <= c3;
            s3_d_reg[0] <= s3;
            c3_d_reg[1] <= c3_d_reg[0];
            s3_d_reg[1] <= s3_d_reg[0];
        end
    end

    assign m_tvalid = valid_reg[L-1];
    assign m_tdata  = {{(p3fk_pkg::OUT_TDATA_W - p3fk_pkg::OUT_W){1'b0}},
                       s3_d_reg[1], c3_d_reg[1], head_reg[L-1], tip_y, tip_x};

endmodule

@@ rtl/p3fk_checker.sv @@
// Port-level checker for the kinematics unit, bound to the top level.
`timescale 1ns / 1ps
`include "planar_three_link_forward_kinematics_unit_assert.svh"

module p3fk_checker (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [p3fk_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // A stalled result keeps its valid and its payload.
    `P3FK_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    // Input is ready exactly when the output side can move.
    `P3FK_ASSERT(a_ready_rule, clk, rst_n, s_tready == (!m_tvalid || m_tready), "ready does not follow output side")
    // Saturated cosine and sine never reach the most negative code.
    `P3FK_ASSERT(a_trig_range, clk, rst_n, m_tvalid |-> (m_tdata[69:54] != 16'h8000) && (m_tdata[85:70] != 16'h8000), "trig value out of range")
    // No result is shown while reset is held.
    `P3FK_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !m_tvalid, "result valid in reset")

endmodule

bind planar_three_link_forward_kinematics_unit p3fk_checker u_p3fk_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
